/* design/skfk_pkg.sv */
`timescale 1ns / 1ps

package skfk_pkg;

  // field widths of the column and result beats
  localparam int WORD_W   = 32;
  localparam int NODE_W   = 6;
  localparam int PARENT_W = 7;
  localparam int COL_W    = 2;
  localparam int ROWS     = 4;
  localparam int POS_DIM  = 3;

  // column code that closes a node's matrix
  localparam logic [COL_W-1:0] COL_LAST = 2'd3;

  // saturation limits of a signed word
  localparam logic [WORD_W-1:0] WORD_MAX = 32'h7fff_ffff;
  localparam logic [WORD_W-1:0] WORD_MIN = 32'h8000_0000;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [ROWS-1:0][WORD_W-1:0] col_t;
  // indexed [column][row]
  typedef logic [ROWS-1:0][ROWS-1:0][WORD_W-1:0] mat_t;
  typedef logic [POS_DIM-1:0][WORD_W-1:0] pos_t;

  // finished world column 3 on its way to the result stage
  typedef struct packed {
    logic [NODE_W-1:0] node;
    col_t              world;
    pos_t              parent_pos;
    logic              has_parent;
  } pos_beat_t;

endpackage

/* design/skfk_in_if.sv */
`timescale 1ns / 1ps

interface skfk_in_if;
  logic                                valid;
  logic                                ready;
  logic        [skfk_pkg::NODE_W-1:0]   node_index;
  logic signed [skfk_pkg::PARENT_W-1:0] parent_index;
  logic        [skfk_pkg::COL_W-1:0]    column;
  logic signed [skfk_pkg::WORD_W-1:0]   elem_row0;
  logic signed [skfk_pkg::WORD_W-1:0]   elem_row1;
  logic signed [skfk_pkg::WORD_W-1:0]   elem_row2;
  logic signed [skfk_pkg::WORD_W-1:0]   elem_row3;

  modport source (
    output valid, node_index, parent_index, column,
    output elem_row0, elem_row1, elem_row2, elem_row3,
    input  ready
  );

  modport sink (
    input  valid, node_index, parent_index, column,
    input  elem_row0, elem_row1, elem_row2, elem_row3,
    output ready
  );
endinterface

/* design/skfk_out_if.sv */
`timescale 1ns / 1ps

interface skfk_out_if;
  logic                              valid;
  logic                              ready;
  logic        [skfk_pkg::NODE_W-1:0] out_node;
  logic signed [skfk_pkg::WORD_W-1:0] world_x;
  logic signed [skfk_pkg::WORD_W-1:0] world_y;
  logic signed [skfk_pkg::WORD_W-1:0] world_z;
  logic signed [skfk_pkg::WORD_W-1:0] world_w;
  logic signed [skfk_pkg::WORD_W-1:0] local_x;
  logic signed [skfk_pkg::WORD_W-1:0] local_y;
  logic signed [skfk_pkg::WORD_W-1:0] local_z;
  logic                              has_parent;

  modport source (
    output valid, out_node, world_x, world_y, world_z, world_w,
    output local_x, local_y, local_z, has_parent,
    input  ready
  );

  modport sink (
    input  valid, out_node, world_x, world_y, world_z, world_w,
    input  local_x, local_y, local_z, has_parent,
    output ready
  );
endinterface

/* design/skeleton_forward_kinematics_top.sv */
`timescale 1ns / 1ps

// Forward kinematics over a skeleton, one column of a node's 4x4 local
// transform per beat, Q(31-FRAC_BITS).FRAC_BITS fixed point. Each beat is
// multiplied by the stored world matrix of its parent (identity for a root,
// including a parent index not below the node index), rounded half up and
// saturated, and the world column is stored under the node. The beat that
// carries column 3 yields one result beat with the world position and the
// offset from the parent's world position; other columns yield none, and a
// node index at or above MAX_NODES is dropped. A beat is taken every cycle
// unless a column 3 beat in stage 1 waits on a stalled hold stage. The sixteen
// multiply-adds are combinational between the input register and the hold
// stage. Parents are read from four column memories of MAX_NODES entries
// each; a child right behind its parent's last column picks that column up
// from a bypass register. The memories are not cleared, so a parent must
// have all four columns sent before its children.
module skeleton_forward_kinematics_top #(
  parameter int MAX_NODES = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  skfk_in_if.sink    column_ch,
  skfk_out_if.source result_ch
);
  import skfk_pkg::*;

  localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int IW = ((AW > NODE_W) ? AW : NODE_W) + 1;
  localparam logic [IW-1:0] NODE_LIMIT = IW'(MAX_NODES);

  logic              in_fire;
  logic              in_node_ok;
  logic              in_par_ok;
  logic [IW-1:0]     in_par_ext;
  logic [IW-1:0]     in_node_ext;
  col_t              in_elem;

  logic              s1_valid;
  logic [NODE_W-1:0] s1_node;
  logic [COL_W-1:0]  s1_col;
  col_t              s1_elem;
  logic              s1_has_parent;
  logic [IW-1:0]     s1_node_ext;
  logic              s1_result;
  logic              s1_fire;

  logic [ROWS-1:0]   fwd_hit;
  logic [ROWS-1:0]   fwd_next;
  col_t              fwd_data;

  mat_t              rd_mat;
  mat_t              pmat;
  col_t              world;
  logic [ROWS-1:0]   wr_en;

  logic              beat_valid;
  logic              beat_ready;
  pos_beat_t         beat;

  // input decode
  assign in_fire     = column_ch.valid && column_ch.ready;
  assign in_node_ext = IW'(column_ch.node_index);
  assign in_par_ext  = IW'(column_ch.parent_index[NODE_W-1:0]);
  assign in_node_ok  = in_node_ext < NODE_LIMIT;
  assign in_par_ok   = !column_ch.parent_index[PARENT_W-1]
                    && (column_ch.parent_index[NODE_W-1:0] < column_ch.node_index);
  assign in_elem     = {column_ch.elem_row3, column_ch.elem_row2,
                        column_ch.elem_row1, column_ch.elem_row0};

  // stage 1 handshake: a column beat only waits when it carries a result
  assign s1_result       = (s1_col == COL_LAST);
  assign s1_fire         = s1_valid && (!s1_result || beat_ready);
  assign column_ch.ready = !s1_valid || s1_fire;
  assign s1_node_ext     = IW'(s1_node);

  // bypass the column leaving stage 1 when the new beat is its child
  always_comb begin
    fwd_next = '0;
    if (s1_valid && in_par_ok && s1_node == column_ch.parent_index[NODE_W-1:0]) begin
      fwd_next = ROWS'(1) << s1_col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_hit  <= '0;
    end else begin
      if (column_ch.ready) begin
        s1_valid <= in_fire && in_node_ok;
      end
      if (in_fire) begin
        fwd_hit <= fwd_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_node       <= column_ch.node_index;
      s1_col        <= column_ch.column;
      s1_elem       <= in_elem;
      s1_has_parent <= in_par_ok;
      fwd_data      <= world;
    end
  end

  // parent world matrix, one memory per column
  for (genvar k = 0; k < ROWS; k++) begin : g_col
    assign wr_en[k] = s1_fire && (s1_col == COL_W'(k));

    skfk_wmem #(
      .DEPTH (MAX_NODES),
      .AW    (AW)
    ) u_wmem (
      .clk     (clk),
      .wr_en   (wr_en[k]),
      .wr_addr (s1_node_ext[AW-1:0]),
      .wr_data (world),
      .rd_en   (in_fire),
      .rd_addr (in_par_ext[AW-1:0]),
      .rd_data (rd_mat[k])
    );

    assign pmat[k] = fwd_hit[k] ? fwd_data : rd_mat[k];
  end

  // world column
  skfk_mac #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .pmat       (pmat),
    .elem       (s1_elem),
    .has_parent (s1_has_parent),
    .world      (world)
  );

  // column 3 goes on to the result stage
  assign beat_valid      = s1_fire && s1_result;
  assign beat.node       = s1_node;
  assign beat.world      = world;
  assign beat.parent_pos = pmat[ROWS-1][POS_DIM-1:0];
  assign beat.has_parent = s1_has_parent;

  skfk_out u_out (
    .clk        (clk),
    .rst        (rst),
    .beat_valid (beat_valid),
    .beat       (beat),
    .beat_ready (beat_ready),
    .result_ch  (result_ch)
  );

endmodule

/* design/skfk_wmem.sv */
`timescale 1ns / 1ps

module skfk_wmem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  skfk_pkg::col_t   wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output skfk_pkg::col_t   rd_data
);
  import skfk_pkg::*;

  col_t mem [DEPTH];

  // one world column per node, no reset
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, old data on a same-edge write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/skfk_mac.sv */
`timescale 1ns / 1ps

module skfk_mac #(
  parameter int FRAC_BITS = 16
) (
  input  skfk_pkg::mat_t pmat,
  input  skfk_pkg::col_t elem,
  input  logic           has_parent,
  output skfk_pkg::col_t world
);
  import skfk_pkg::*;

  localparam int PW = 2 * WORD_W;
  localparam int SW = PW + 2;

  logic signed [PW-1:0] prod    [ROWS][ROWS];
  logic signed [SW-1:0] acc     [ROWS];
  logic signed [SW-1:0] shifted [ROWS];
  logic signed [SW-1:0] half;

  assign half = SW'(1) << (FRAC_BITS - 1);

  // sixteen products, row sums, round half up, saturate; a root passes its column through
  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      for (int k = 0; k < ROWS; k++) begin
        prod[r][k] = $signed(pmat[k][r]) * $signed(elem[k]);
      end
    end
    for (int r = 0; r < ROWS; r++) begin
      acc[r] = half;
      for (int k = 0; k < ROWS; k++) begin
        acc[r] = acc[r] + SW'(prod[r][k]);
      end
      shifted[r] = acc[r] >>> FRAC_BITS;
      if (!has_parent) begin
        world[r] = elem[r];
      end else if (shifted[r][SW-1:WORD_W-1] == '0 || shifted[r][SW-1:WORD_W-1] == '1) begin
        world[r] = shifted[r][WORD_W-1:0];
      end else begin
        world[r] = shifted[r][SW-1] ? WORD_MIN : WORD_MAX;
      end
    end
  end

endmodule

/* design/skfk_out.sv */
`timescale 1ns / 1ps

module skfk_out (
  input  logic                clk,
  input  logic                rst,
  input  logic                beat_valid,
  input  skfk_pkg::pos_beat_t beat,
  output logic                beat_ready,
  skfk_out_if.source          result_ch
);
  import skfk_pkg::*;

  logic                 s2_valid;
  pos_beat_t            s2_beat;
  logic                 s2_fire;
  logic                 out_valid;
  logic [NODE_W-1:0]    out_node;
  col_t                 out_world;
  pos_t                 out_local;
  logic                 out_has_parent;
  logic [WORD_W:0]      diff [POS_DIM];
  pos_t                 local_next;

  assign s2_fire    = s2_valid && (!out_valid || result_ch.ready);
  assign beat_ready = !s2_valid || s2_fire;

  // hold stage for the world column
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (beat_ready) begin
      s2_valid <= beat_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (beat_ready && beat_valid) begin
      s2_beat <= beat;
    end
  end

  // offset from the parent position, saturated, zero for a root
  always_comb begin
    for (int r = 0; r < POS_DIM; r++) begin
      diff[r] = {s2_beat.world[r][WORD_W-1], s2_beat.world[r]}
              - {s2_beat.parent_pos[r][WORD_W-1], s2_beat.parent_pos[r]};
      if (!s2_beat.has_parent) begin
        local_next[r] = '0;
      end else if (diff[r][WORD_W] != diff[r][WORD_W-1]) begin
        local_next[r] = diff[r][WORD_W] ? WORD_MIN : WORD_MAX;
      end else begin
        local_next[r] = diff[r][WORD_W-1:0];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_fire) begin
      out_valid <= 1'b1;
    end else if (result_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      out_node       <= s2_beat.node;
      out_world      <= s2_beat.world;
      out_local      <= local_next;
      out_has_parent <= s2_beat.has_parent;
    end
  end

  assign result_ch.valid      = out_valid;
  assign result_ch.out_node   = out_node;
  assign result_ch.world_x    = out_world[0];
  assign result_ch.world_y    = out_world[1];
  assign result_ch.world_z    = out_world[2];
  assign result_ch.world_w    = out_world[3];
  assign result_ch.local_x    = out_local[0];
  assign result_ch.local_y    = out_local[1];
  assign result_ch.local_z    = out_local[2];
  assign result_ch.has_parent = out_has_parent;

endmodule
